// File: rtl/hahn_polynomial_evaluator_unit_defines.svh
// ---------------------------------------------------------------------------
// Hahn polynomial evaluator: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef HAHN_POLYNOMIAL_EVALUATOR_UNIT_DEFINES_SVH
`define HAHN_POLYNOMIAL_EVALUATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define HPE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hpe assertion failed");
// Next-cycle implication, disabled in reset
`define HPE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hpe assertion failed");
`else
`define HPE_ASSERT_IMP(label, clk, rst, ante, cons)
`define HPE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/hpe_pkg.sv
// ---------------------------------------------------------------------------
// hpe_pkg
// Types, constants, microprogram and arithmetic helpers of the Hahn
// polynomial evaluator.
// ---------------------------------------------------------------------------
package hpe_pkg;

  localparam int DEF_MAX_ORDER = 15;
  localparam int PC_W = 6;

  localparam logic [63:0] ONE_Q   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TWO_Q   = 64'h0000_0002_0000_0000;
  localparam logic [63:0] THREE_Q = 64'h0000_0003_0000_0000;
  localparam logic [63:0] FOUR_Q  = 64'h0000_0004_0000_0000;
  localparam logic [63:0] QMAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QMIN    = 64'h8000_0000_0000_0000;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALPHA = 2'd0;
  localparam logic [1:0] CFG_BETA  = 2'd1;
  localparam logic [1:0] CFG_POPN  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} hpe_op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_START, S_WAIT, S_RDOUT, S_DONE
  } hpe_state_t;

  // Scratch slots
  localparam logic [3:0] R_S    = 4'd0;
  localparam logic [3:0] R_AP1  = 4'd1;
  localparam logic [3:0] R_D1   = 4'd2;
  localparam logic [3:0] R_T    = 4'd3;
  localparam logic [3:0] R_PREV = 4'd4;
  localparam logic [3:0] R_S3   = 4'd5;
  localparam logic [3:0] R_W    = 4'd6;
  localparam logic [3:0] R_D2   = 4'd7;
  localparam logic [3:0] R_XX   = 4'd8;
  localparam logic [3:0] R_CUR  = 4'd9;
  localparam logic [3:0] R_SM   = 4'd10;
  localparam logic [3:0] R_TM   = 4'd11;
  localparam logic [3:0] R_AN   = 4'd12;
  localparam logic [3:0] R_AD   = 4'd13;
  localparam logic [3:0] R_CN   = 4'd14;
  localparam logic [3:0] R_CD   = 4'd15;

  // Operand sources: bit 4 clear selects a scratch slot
  localparam logic [4:0] SRC_X     = 5'h10;
  localparam logic [4:0] SRC_A     = 5'h11;
  localparam logic [4:0] SRC_B     = 5'h12;
  localparam logic [4:0] SRC_NQ    = 5'h13;
  localparam logic [4:0] SRC_MQ    = 5'h14;
  localparam logic [4:0] SRC_ZERO  = 5'h15;
  localparam logic [4:0] SRC_ONE   = 5'h16;
  localparam logic [4:0] SRC_TWO   = 5'h17;
  localparam logic [4:0] SRC_THREE = 5'h18;
  localparam logic [4:0] SRC_FOUR  = 5'h19;

  // Program landmarks
  localparam logic [PC_W-1:0] PC_N1_EXIT   = 6'd6;
  localparam logic [PC_W-1:0] PC_P_END     = 6'd23;
  localparam logic [PC_W-1:0] PC_COPY_PREV = 6'd24;
  localparam logic [PC_W-1:0] PC_LOAD_ONE  = 6'd25;
  localparam logic [PC_W-1:0] PC_LOOP      = 6'd26;
  localparam logic [PC_W-1:0] PC_LOOP_END  = 6'd53;

  typedef struct packed {
    hpe_op_t    op;
    logic [3:0] dst;
    logic [4:0] src_a;
    logic [4:0] src_b;
  } hpe_uop_t;

  typedef struct packed {
    logic       load;
    logic       start;
    hpe_op_t    op;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic       wr;
    logic [3:0] dst;
    logic       capture;
  } hpe_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } hpe_stat_t;

  function automatic logic [4:0] rs(input logic [3:0] slot);
    return {1'b0, slot};
  endfunction

  function automatic hpe_uop_t mk(input hpe_op_t op, input logic [3:0] dst,
                                  input logic [4:0] a, input logic [4:0] b);
    hpe_uop_t u;
    u.op = op;
    u.dst = dst;
    u.src_a = a;
    u.src_b = b;
    return u;
  endfunction

  // Microprogram: closed forms, order selection copies, recurrence body
  function automatic hpe_uop_t prog_rom(input logic [PC_W-1:0] pc);
    hpe_uop_t u;
    case (pc)
      6'd0:  u = mk(OP_ADD, R_S,    SRC_A,      SRC_B);
      6'd1:  u = mk(OP_ADD, R_AP1,  SRC_A,      SRC_ONE);
      6'd2:  u = mk(OP_MUL, R_D1,   SRC_NQ,     rs(R_AP1));
      6'd3:  u = mk(OP_ADD, R_T,    rs(R_S),    SRC_TWO);
      6'd4:  u = mk(OP_DIV, R_T,    rs(R_T),    rs(R_D1));
      6'd5:  u = mk(OP_MUL, R_T,    rs(R_T),    SRC_X);
      6'd6:  u = mk(OP_SUB, R_PREV, SRC_ONE,    rs(R_T));
      6'd7:  u = mk(OP_ADD, R_S3,   rs(R_S),    SRC_THREE);
      6'd8:  u = mk(OP_DIV, R_W,    rs(R_S3),   rs(R_D1));
      6'd9:  u = mk(OP_ADD, R_W,    rs(R_W),    rs(R_W));
      6'd10: u = mk(OP_MUL, R_W,    rs(R_W),    SRC_X);
      6'd11: u = mk(OP_ADD, R_D2,   SRC_A,      SRC_TWO);
      6'd12: u = mk(OP_MUL, R_D2,   rs(R_AP1),  rs(R_D2));
      6'd13: u = mk(OP_MUL, R_D2,   rs(R_D2),   SRC_NQ);
      6'd14: u = mk(OP_SUB, R_T,    SRC_NQ,     SRC_ONE);
      6'd15: u = mk(OP_MUL, R_D2,   rs(R_D2),   rs(R_T));
      6'd16: u = mk(OP_ADD, R_T,    rs(R_S),    SRC_FOUR);
      6'd17: u = mk(OP_MUL, R_T,    rs(R_S3),   rs(R_T));
      6'd18: u = mk(OP_DIV, R_T,    rs(R_T),    rs(R_D2));
      6'd19: u = mk(OP_SUB, R_XX,   SRC_X,      SRC_ONE);
      6'd20: u = mk(OP_MUL, R_XX,   SRC_X,      rs(R_XX));
      6'd21: u = mk(OP_MUL, R_T,    rs(R_T),    rs(R_XX));
      6'd22: u = mk(OP_SUB, R_W,    SRC_ONE,    rs(R_W));
      6'd23: u = mk(OP_ADD, R_CUR,  rs(R_W),    rs(R_T));
      6'd24: u = mk(OP_ADD, R_CUR,  rs(R_PREV), SRC_ZERO);
      6'd25: u = mk(OP_ADD, R_CUR,  SRC_ONE,    SRC_ZERO);
      6'd26: u = mk(OP_ADD, R_SM,   rs(R_S),    SRC_MQ);
      6'd27: u = mk(OP_ADD, R_TM,   rs(R_SM),   SRC_MQ);
      6'd28: u = mk(OP_ADD, R_AN,   rs(R_SM),   SRC_ONE);
      6'd29: u = mk(OP_ADD, R_AD,   SRC_A,      SRC_MQ);
      6'd30: u = mk(OP_ADD, R_AD,   rs(R_AD),   SRC_ONE);
      6'd31: u = mk(OP_MUL, R_AN,   rs(R_AN),   rs(R_AD));
      6'd32: u = mk(OP_SUB, R_AD,   SRC_NQ,     SRC_MQ);
      6'd33: u = mk(OP_MUL, R_AN,   rs(R_AN),   rs(R_AD));
      6'd34: u = mk(OP_ADD, R_AD,   rs(R_TM),   SRC_ONE);
      6'd35: u = mk(OP_ADD, R_CN,   rs(R_TM),   SRC_TWO);
      6'd36: u = mk(OP_MUL, R_AD,   rs(R_AD),   rs(R_CN));
      6'd37: u = mk(OP_ADD, R_CN,   rs(R_SM),   SRC_NQ);
      6'd38: u = mk(OP_ADD, R_CN,   rs(R_CN),   SRC_ONE);
      6'd39: u = mk(OP_MUL, R_CN,   SRC_MQ,     rs(R_CN));
      6'd40: u = mk(OP_ADD, R_CD,   SRC_MQ,     SRC_B);
      6'd41: u = mk(OP_MUL, R_CN,   rs(R_CN),   rs(R_CD));
      6'd42: u = mk(OP_ADD, R_CD,   rs(R_TM),   SRC_ONE);
      6'd43: u = mk(OP_MUL, R_CD,   rs(R_TM),   rs(R_CD));
      6'd44: u = mk(OP_DIV, R_AN,   rs(R_AN),   rs(R_AD));
      6'd45: u = mk(OP_DIV, R_CN,   rs(R_CN),   rs(R_CD));
      6'd46: u = mk(OP_ADD, R_AD,   rs(R_AN),   rs(R_CN));
      6'd47: u = mk(OP_SUB, R_AD,   rs(R_AD),   SRC_X);
      6'd48: u = mk(OP_MUL, R_AD,   rs(R_AD),   rs(R_CUR));
      6'd49: u = mk(OP_MUL, R_CD,   rs(R_CN),   rs(R_PREV));
      6'd50: u = mk(OP_SUB, R_AD,   rs(R_AD),   rs(R_CD));
      6'd51: u = mk(OP_DIV, R_AD,   rs(R_AD),   rs(R_AN));
      6'd52: u = mk(OP_ADD, R_PREV, rs(R_CUR),  SRC_ZERO);
      6'd53: u = mk(OP_ADD, R_CUR,  rs(R_AD),   SRC_ZERO);
      default: u = mk(OP_ADD, R_CUR, SRC_ZERO,  SRC_ZERO);
    endcase
    return u;
  endfunction

  function automatic logic [63:0] magn(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Clamp a sign and magnitude to the signed 64-bit range; bit 64 flags clamping
  function automatic logic [64:0] sat_signed(input logic neg, input logic [63:0] mag,
                                             input logic over);
    logic [64:0] r;
    if (neg) begin
      if (over || (mag > QMIN)) r = {1'b1, QMIN};
      else r = {1'b0, 64'd0 - mag};
    end else begin
      if (over || mag[63]) r = {1'b1, QMAX};
      else r = {1'b0, mag};
    end
    return r;
  endfunction

endpackage

// File: rtl/hpe_ram.sv
// ---------------------------------------------------------------------------
// hpe_ram
// Generic RAM, one write port and two registered read ports.
// ---------------------------------------------------------------------------
module hpe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/hpe_ctrl.sv
// ---------------------------------------------------------------------------
// hpe_ctrl
// Sequencer: steps the microprogram, picks the closed form or recurrence
// path by order, and hands the result to the output register.
// ---------------------------------------------------------------------------
module hpe_ctrl import hpe_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  localparam int ORD_W = $clog2(MAX_ORDER + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       in_order,
  output hpe_cmd_t         cmd,
  output logic [ORD_W-1:0] m,
  input  hpe_stat_t        stat
);

  hpe_state_t       state, state_next;
  logic [PC_W-1:0]  pc, pc_next;
  logic [ORD_W-1:0] ord, ord_next;
  logic [ORD_W-1:0] m_next;
  hpe_uop_t         uop;

  assign uop = prog_rom(pc);

  // State and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      ord <= '0;
      m <= '0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      ord <= ord_next;
      m <= m_next;
    end
  end

  // Next state and program counter
  always_comb begin
    state_next = state;
    pc_next = pc;
    ord_next = ord;
    m_next = m;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (int'(in_order) > MAX_ORDER) ord_next = ORD_W'(MAX_ORDER);
          else ord_next = ORD_W'(in_order);
          pc_next = (in_order == 4'd0) ? PC_LOAD_ONE : '0;
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT: begin
        if (stat.done) begin
          state_next = S_READ;
          unique case (pc)
            PC_N1_EXIT: begin
              pc_next = (ord == ORD_W'(1)) ? PC_COPY_PREV : pc + 1'b1;
            end
            PC_P_END: begin
              if (ord == ORD_W'(2)) begin
                state_next = S_RDOUT;
              end else begin
                m_next = ORD_W'(2);
                pc_next = PC_LOOP;
              end
            end
            PC_COPY_PREV, PC_LOAD_ONE: state_next = S_RDOUT;
            PC_LOOP_END: begin
              if ((m + ORD_W'(1)) == ord) begin
                state_next = S_RDOUT;
              end else begin
                m_next = m + ORD_W'(1);
                pc_next = PC_LOOP;
              end
            end
            default: pc_next = pc + 1'b1;
          endcase
        end
      end
      S_RDOUT: state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.start = (state == S_START);
    cmd.op = uop.op;
    cmd.src_a = ((state == S_RDOUT) || (state == S_DONE)) ? rs(R_CUR) : uop.src_a;
    cmd.src_b = uop.src_b;
    cmd.wr = (state == S_WAIT) && stat.done;
    cmd.dst = uop.dst;
    cmd.capture = (state == S_DONE) && stat.out_free;
  end

endmodule

// File: rtl/hpe_datapath.sv
// ---------------------------------------------------------------------------
// hpe_datapath
// Configuration registers, scratch RAM, saturating add/sub, a four-pass
// 32x32 multiplier, a bit-serial divider, status flags and output register.
// ---------------------------------------------------------------------------
module hpe_datapath import hpe_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  localparam int ORD_W = $clog2(MAX_ORDER + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [24:0]      cfg_wdata,
  input  logic [31:0]      in_x,
  input  hpe_cmd_t         cmd,
  input  logic [ORD_W-1:0] m,
  output hpe_stat_t        stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      out_value,
  output logic [1:0]       out_status
);

  logic [24:0] alpha, beta;
  logic [15:0] popn;
  logic [31:0] x_q;
  logic [63:0] qa, qb, qx, qnq, qmq;
  logic [63:0] rdata_a, rdata_b, opa, opb;
  logic        flag_sat, flag_div0;

  hpe_op_t     u_op;
  logic        u_busy, u_round, u_done;
  logic [6:0]  u_step;
  logic [63:0] u_a, u_b, u_ma, u_mb;
  logic        u_neg;
  logic [127:0] u_acc;
  logic [63:0] u_rem;
  logic [95:0] u_dvd, u_q;
  logic [63:0] res;
  logic        res_sat, res_div0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= '0;
      beta <= '0;
      popn <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ALPHA: alpha <= cfg_wdata;
        CFG_BETA:  beta <= cfg_wdata;
        CFG_POPN:  popn <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Operands in Q32.32
  assign qa = {{23{alpha[24]}}, alpha, 16'd0};
  assign qb = {{23{beta[24]}}, beta, 16'd0};
  assign qx = {{16{x_q[31]}}, x_q, 16'd0};
  assign qnq = {16'd0, popn, 32'd0};
  assign qmq = 64'(m) << 32;

  hpe_ram #(.WIDTH(64), .DEPTH(16)) u_ram (
    .clk    (clk),
    .we     (cmd.wr),
    .waddr  (cmd.dst),
    .wdata  (res),
    .raddr_a(cmd.src_a[3:0]),
    .raddr_b(cmd.src_b[3:0]),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  function automatic logic [63:0] pick(input logic [4:0] src, input logic [63:0] rd);
    logic [63:0] v;
    unique case (src)
      SRC_X:     v = qx;
      SRC_A:     v = qa;
      SRC_B:     v = qb;
      SRC_NQ:    v = qnq;
      SRC_MQ:    v = qmq;
      SRC_ONE:   v = ONE_Q;
      SRC_TWO:   v = TWO_Q;
      SRC_THREE: v = THREE_Q;
      SRC_FOUR:  v = FOUR_Q;
      default:   v = src[4] ? 64'd0 : rd;
    endcase
    return v;
  endfunction

  assign opa = pick(cmd.src_a, rdata_a);
  assign opb = pick(cmd.src_b, rdata_b);

  // Saturating add and subtract
  logic [64:0] sum65;
  logic [64:0] addsub_res;
  always_comb begin
    if (u_op == OP_SUB) sum65 = {u_a[63], u_a} - {u_b[63], u_b};
    else sum65 = {u_a[63], u_a} + {u_b[63], u_b};
    if (sum65[64] != sum65[63]) addsub_res = {1'b1, sum65[64] ? QMIN : QMAX};
    else addsub_res = {1'b0, sum65[63:0]};
  end

  // One 32x32 partial product per pass, accumulated at its weight
  logic [31:0]  a_sl, b_sl;
  logic [63:0]  pp;
  logic [127:0] pp_sh, mul_rnd;
  logic [64:0]  mul_res;
  always_comb begin
    a_sl = u_step[1] ? u_ma[63:32] : u_ma[31:0];
    b_sl = u_step[0] ? u_mb[63:32] : u_mb[31:0];
    pp = 64'(a_sl) * 64'(b_sl);
    unique case (u_step[1:0])
      2'd0:       pp_sh = 128'(pp);
      2'd1, 2'd2: pp_sh = 128'(pp) << 32;
      default:    pp_sh = 128'(pp) << 64;
    endcase
    mul_rnd = u_acc + 128'h8000_0000;
    mul_res = sat_signed(u_neg, mul_rnd[95:32], |mul_rnd[127:96]);
  end

  // Restoring division step and round-to-nearest finish
  logic [64:0] rem_sh, rem_new;
  logic        ge, up, div_over;
  logic [63:0] q_rnd;
  logic [64:0] div_res;
  always_comb begin
    rem_sh = {u_rem, u_dvd[95]};
    ge = rem_sh >= {1'b0, u_mb};
    rem_new = ge ? (rem_sh - {1'b0, u_mb}) : rem_sh;
    up = u_rem >= (u_mb - u_rem);
    q_rnd = u_q[63:0] + 64'(up);
    div_over = (|u_q[95:64]) || (up && (&u_q[63:0]));
    div_res = sat_signed(u_neg, q_rnd, div_over);
  end

  // Arithmetic unit sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      u_busy <= 1'b0;
      u_done <= 1'b0;
    end else begin
      u_done <= 1'b0;
      if (cmd.start) begin
        u_busy <= 1'b1;
        u_round <= 1'b0;
        u_op <= cmd.op;
        u_a <= opa;
        u_b <= opb;
        u_ma <= magn(opa);
        u_mb <= magn(opb);
        u_neg <= opa[63] ^ opb[63];
        u_step <= (cmd.op == OP_DIV) ? 7'd95 : 7'd0;
        u_acc <= '0;
        u_rem <= '0;
        u_dvd <= {magn(opa), 32'd0};
        u_q <= '0;
      end else if (u_busy) begin
        unique case (u_op)
          OP_ADD, OP_SUB: begin
            {res_sat, res} <= addsub_res;
            res_div0 <= 1'b0;
            u_busy <= 1'b0;
            u_done <= 1'b1;
          end
          OP_MUL: begin
            if (!u_round) begin
              u_acc <= u_acc + pp_sh;
              u_step <= u_step + 7'd1;
              if (u_step == 7'd3) u_round <= 1'b1;
            end else begin
              {res_sat, res} <= mul_res;
              res_div0 <= 1'b0;
              u_busy <= 1'b0;
              u_done <= 1'b1;
            end
          end
          default: begin
            if (u_mb == 64'd0) begin
              res <= '0;
              res_sat <= 1'b0;
              res_div0 <= 1'b1;
              u_busy <= 1'b0;
              u_done <= 1'b1;
            end else if (!u_round) begin
              u_rem <= rem_new[63:0];
              u_dvd <= u_dvd << 1;
              u_q <= {u_q[94:0], ge};
              if (u_step == 7'd0) u_round <= 1'b1;
              else u_step <= u_step - 7'd1;
            end else begin
              {res_sat, res} <= div_res;
              res_div0 <= 1'b0;
              u_busy <= 1'b0;
              u_done <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Item latch and sticky flags
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_sat <= 1'b0;
      flag_div0 <= 1'b0;
    end else if (cmd.load) begin
      flag_sat <= 1'b0;
      flag_div0 <= 1'b0;
    end else if (u_done) begin
      flag_sat <= flag_sat | res_sat;
      flag_div0 <= flag_div0 | res_div0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) x_q <= in_x;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_value <= flag_div0 ? 64'd0 : rdata_a;
      out_status <= flag_div0 ? ST_DIV0 : (flag_sat ? ST_SAT : ST_OK);
    end
  end

  assign stat.done = u_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

// File: rtl/hahn_polynomial_evaluator_unit.sv
// ---------------------------------------------------------------------------
// hahn_polynomial_evaluator_unit
// Evaluates the Hahn polynomial Q_n(x; alpha, beta, N) in Q32.32 by closed
// forms up to order two and the three-term recurrence above.
//
//   port group   dir  contents
//   s_axis       in   point x (Q16.16) and order n
//   m_axis       out  Q_n(x) (Q32.32) and status
//   cfg          in   alpha, beta, N register writes
//
// One item at a time. Each operation passes through the read, start and
// wait states around its unit; divide uses the bit-serial divider.
// Reset (rst, synchronous) clears the sequencer, flags and output valid, and sets alpha, beta to 0 and N to 1.
// A stalled result waits in the output register; the next item may enter
// meanwhile and waits at completion for the register to free.
// ---------------------------------------------------------------------------
`include "hahn_polynomial_evaluator_unit_defines.svh"

module hahn_polynomial_evaluator_unit import hpe_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] x_value, [35:32] poly_order
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] poly_value
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [24:0] cfg_wdata
);

  localparam int ORD_W = $clog2(MAX_ORDER + 1);

  hpe_cmd_t         dp_cmd;
  hpe_stat_t        dp_stat;
  logic [ORD_W-1:0] m;

  hpe_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_order(s_axis_tdata[35:32]),
    .cmd     (dp_cmd),
    .m       (m),
    .stat    (dp_stat)
  );

  hpe_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_x      (s_axis_tdata[31:0]),
    .cmd       (dp_cmd),
    .m         (m),
    .stat      (dp_stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (m_axis_tdata),
    .out_status(m_axis_tuser)
  );

  // Scratch writes only land with a finished unit result
  `HPE_ASSERT_IMP(a_wr_on_done, clk, rst, dp_cmd.wr, dp_stat.done)
  // No unit finishes in the cycle right after it starts
  `HPE_ASSERT_NXT(a_no_early_done, clk, rst, dp_cmd.start, !dp_stat.done)
  // The unit is quiet while the block waits for an item
  `HPE_ASSERT_IMP(a_idle_quiet, clk, rst, s_axis_tready, !dp_stat.done && !dp_cmd.start)
  // A division by zero always reports a zero value
  `HPE_ASSERT_IMP(a_div0_zero, clk, rst, m_axis_tvalid && (m_axis_tuser == ST_DIV0),
                  m_axis_tdata == 64'd0)

endmodule
